// ===== rtl/cpec_pkg.sv =====
`default_nettype none
package cpec_pkg;

  localparam int NUM_IC          = 2;
  localparam int CELLS_PER_GROUP = 3;
  localparam int NUM_GROUPS      = 6;
  localparam int CELLS_PER_CHIP  = CELLS_PER_GROUP * NUM_GROUPS;
  localparam int DATA_BYTES      = 6;
  localparam int CNT_W           = 16;
  localparam int BASE_W          = 6;
  localparam int POS_W           = 3;

  // one counter row per group of each chip: three cells of one group of one chip
  localparam int NUM_ROWS        = NUM_GROUPS * NUM_IC;
  localparam int ROW_W           = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int ROW_SUM_W       = ROW_W + 1;

  localparam logic [15:0] CRC_SEED = 16'd16;
  localparam logic [15:0] CRC_POLY = 16'h4599;

  localparam logic [POS_W-1:0] POS_DATA_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_DATA_LAST  = 3'd5;
  localparam logic [POS_W-1:0] POS_PEC_HI     = 3'd6;
  localparam logic [POS_W-1:0] POS_PEC_LO     = 3'd7;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic wr;   // update the row now
    logic hit;  // group and chip map to a real row
    logic ok;   // pec matched
    row_t row;
  } cnt_req_t;

  function automatic logic [15:0] crc_table_entry(input logic [7:0] addr);
    logic [15:0] r;
    r = {1'b0, addr, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_update(input logic [15:0] rem, input logic [7:0] data);
    logic [7:0] addr;
    addr = rem[14:7] ^ data;
    return {rem[7:0], 8'h00} ^ crc_table_entry(addr);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cpec_counters.sv =====
`default_nettype none
module cpec_counters (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cpec_pkg::cnt_req_t req,
  output cpec_pkg::cnt_t         errs_a,
  output cpec_pkg::cnt_t         errs_b,
  output cpec_pkg::cnt_t         errs_c
);
  import cpec_pkg::*;

  cnt_t cnt_r [NUM_ROWS][CELLS_PER_GROUP];
  cnt_t cnt_nxt [CELLS_PER_GROUP];
  row_t row_sel;

  assign row_sel = req.hit ? req.row : '0;

  // clear on good frame, saturating increment on bad one
  always_comb begin
    for (int k = 0; k < CELLS_PER_GROUP; k++) begin
      if (req.ok) begin
        cnt_nxt[k] = '0;
      end else if (&cnt_r[row_sel][k]) begin
        cnt_nxt[k] = cnt_r[row_sel][k];
      end else begin
        cnt_nxt[k] = cnt_r[row_sel][k] + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int k = 0; k < CELLS_PER_GROUP; k++) begin
          cnt_r[r][k] <= '0;
        end
      end
    end else if (req.wr && req.hit) begin
      for (int k = 0; k < CELLS_PER_GROUP; k++) begin
        cnt_r[row_sel][k] <= cnt_nxt[k];
      end
    end
  end

  assign errs_a = req.hit ? cnt_nxt[0] : '0;
  assign errs_b = req.hit ? cnt_nxt[1] : '0;
  assign errs_c = req.hit ? cnt_nxt[2] : '0;

endmodule
`default_nettype wire

// ===== rtl/cell_readout_pec_checker_unit.sv =====
`default_nettype none
// channel   direction  handshake           payload
// in_       input      in_valid/in_ready   rx_byte, frame_start, reg_group, ic_index
// out_      output     out_valid/out_ready cell_base, voltage_a..c, pec_ok, errors_a..c
//
// one byte item is taken per cycle unless a held eighth byte waits on a stalled result;
// each byte is held in the input register and then updates the crc and frame bytes,
// and the eighth byte of a frame passes from the input register into the result register
// synchronous active-low reset clears position, crc seed, valids and all error counters
// a stalled result blocks only the input register holding the next eighth byte;
// data bytes keep flowing while a result waits
module cell_readout_pec_checker_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic [7:0]             in_rx_byte,
  input  wire logic                   in_frame_start,
  input  wire logic [2:0]             in_reg_group,
  input  wire logic                   in_ic_index,
  // result channel
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [5:0]             out_cell_base,
  output      logic [15:0]            out_voltage_a,
  output      logic [15:0]            out_voltage_b,
  output      logic [15:0]            out_voltage_c,
  output      logic                   out_pec_ok,
  output      cpec_pkg::cnt_t         out_errors_a,
  output      cpec_pkg::cnt_t         out_errors_b,
  output      cpec_pkg::cnt_t         out_errors_c
);
  import cpec_pkg::*;

  // input register
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             s1_start_r;
  logic [2:0]       s1_group_r;
  logic             s1_ic_r;

  // frame state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [7:0]       data_r [DATA_BYTES];
  logic [7:0]       pec_hi_r;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [5:0]       cell_base_r;
  logic [15:0]      volt_a_r, volt_b_r, volt_c_r;
  logic             pec_ok_r;
  cnt_t             err_a_r, err_b_r, err_c_r;

  logic [POS_W-1:0]     pos_eff;
  logic [15:0]          rem_eff;
  logic                 s1_is_last;
  logic                 s1_adv;
  logic                 in_fire;
  logic                 res_fire;
  logic                 pec_ok;
  logic                 in_range;
  logic [BASE_W:0]      base_sum;
  logic [ROW_SUM_W-1:0] row_sum;
  cnt_req_t             cnt_req;
  cnt_t                 errs_a, errs_b, errs_c;

  // frame start abandons a partial frame
  assign pos_eff = s1_start_r ? POS_DATA_FIRST : pos_r;
  assign rem_eff = s1_start_r ? CRC_SEED : rem_r;

  assign s1_is_last = s1_valid_r && (pos_eff == POS_PEC_LO);
  // only the last byte needs room in the result register
  assign s1_adv     = s1_valid_r && (!s1_is_last || !out_valid_r || out_ready);
  assign res_fire   = s1_is_last && s1_adv;
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_fire    = in_valid && in_ready;

  // remainder doubled vs big-endian received pec
  assign pec_ok = {rem_r[14:0], 1'b0} == {pec_hi_r, s1_byte_r};

  // first cell index, masked to the port width
  assign base_sum = (BASE_W+1)'(s1_group_r) * (BASE_W+1)'(CELLS_PER_GROUP)
                  + (s1_ic_r ? (BASE_W+1)'(CELLS_PER_CHIP) : '0);

  assign in_range = (s1_group_r < 3'(NUM_GROUPS)) && (32'(s1_ic_r) < NUM_IC);
  assign row_sum  = ROW_SUM_W'(s1_group_r) + (s1_ic_r ? ROW_SUM_W'(NUM_GROUPS) : '0);

  assign cnt_req.wr  = res_fire;
  assign cnt_req.hit = in_range;
  assign cnt_req.ok  = pec_ok;
  assign cnt_req.row = row_sum[ROW_W-1:0];

  cpec_counters u_counters (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cnt_req),
    .errs_a (errs_a),
    .errs_b (errs_b),
    .errs_c (errs_c)
  );

  // position and crc advance
  always_comb begin
    pos_nxt = pos_r;
    rem_nxt = rem_r;
    if (s1_adv) begin
      case (pos_eff) inside
        [POS_DATA_FIRST:POS_DATA_LAST]: begin
          pos_nxt = pos_eff + POS_W'(1);
          rem_nxt = crc_update(rem_eff, s1_byte_r);
        end
        POS_PEC_HI: begin
          pos_nxt = POS_PEC_LO;
          rem_nxt = rem_eff;
        end
        POS_PEC_LO: begin
          // wrap and reseed for a back-to-back frame
          pos_nxt = POS_DATA_FIRST;
          rem_nxt = CRC_SEED;
        end
        default: begin
          pos_nxt = POS_DATA_FIRST;
          rem_nxt = CRC_SEED;
        end
      endcase
    end
  end

  always_comb begin
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= POS_DATA_FIRST;
      rem_r       <= CRC_SEED;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
      s1_group_r <= in_reg_group;
      s1_ic_r    <= in_ic_index;
    end
    for (int i = 0; i < DATA_BYTES; i++) begin
      if (s1_adv && pos_eff == POS_W'(i)) begin
        data_r[i] <= s1_byte_r;
      end
    end
    if (s1_adv && pos_eff == POS_PEC_HI) begin
      pec_hi_r <= s1_byte_r;
    end
    if (res_fire) begin
      cell_base_r <= base_sum[BASE_W-1:0];
      volt_a_r    <= {data_r[1], data_r[0]};
      volt_b_r    <= {data_r[3], data_r[2]};
      volt_c_r    <= {data_r[5], data_r[4]};
      pec_ok_r    <= pec_ok;
      err_a_r     <= errs_a;
      err_b_r     <= errs_b;
      err_c_r     <= errs_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_base = cell_base_r;
  assign out_voltage_a = volt_a_r;
  assign out_voltage_b = volt_b_r;
  assign out_voltage_c = volt_c_r;
  assign out_pec_ok    = pec_ok_r;
  assign out_errors_a  = err_a_r;
  assign out_errors_b  = err_b_r;
  assign out_errors_c  = err_c_r;

  // a finished frame always leaves the engine reseeded at byte zero
  a_wrap_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> (pos_r == POS_DATA_FIRST) && (rem_r == CRC_SEED))
    else $error("frame state not reset after result");

  // a new result only comes from an eighth byte leaving the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res_fire))
    else $error("result without a completed frame");

  // good pec always clears the reported counters
  a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pec_ok) |->
      (out_errors_a == '0) && (out_errors_b == '0) && (out_errors_c == '0))
    else $error("counters nonzero on good frame");

  // input stalls only behind a held eighth byte and a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_is_last && out_valid_r && !out_ready)
    else $error("input stalled without cause");

endmodule
`default_nettype wire
